### sv/mpq_pkg.sv
// Package with the transfer payload types and command and status codes of the priority queue.
package mpq_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic               cmd;
    logic        [15:0] tag;
    logic signed [15:0] priority_req;
  } in_t;

  typedef struct packed {
    logic        [1:0]         status;
    logic        [COUNT_W-1:0] count;
    logic                      top_valid;
    logic        [15:0]        top_tag;
    logic signed [15:0]        top_priority;
  } out_t;

  typedef struct packed {
    logic        [15:0] tag;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

### sv/mpq_datapath.sv
// Datapath of the priority queue: request register, sorted cell chain, count and result register.
module mpq_datapath import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  in_t     in_data_i,
  output out_t    out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  in_t              req_q;
  out_t             out_q;
  out_t             out_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  entry_t           cells_q [CAPACITY];
  entry_t           cells_d [CAPACITY];
  logic             keep    [CAPACITY];
  entry_t           new_entry;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  assign new_entry = '{tag: req_q.tag, prio: req_q.priority_req};
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign do_push   = (req_q.cmd == CMD_PUSH) && !full;
  assign do_pop    = (req_q.cmd == CMD_POP) && !empty;

  // Cells are held in descending priority, earlier insertions first among equals.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign keep[i] = (CNT_W'(i) < count_q) && (cells_q[i].prio >= req_q.priority_req);

    if (i == 0) begin : g_head
      always_comb begin
        if (do_pop) begin
          cells_d[i] = (CAPACITY > 1) ? cells_q[(CAPACITY > 1) ? 1 : 0] : cells_q[i];
        end else if (keep[i]) begin
          cells_d[i] = cells_q[i];
        end else begin
          cells_d[i] = new_entry;
        end
      end
    end else begin : g_body
      always_comb begin
        if (do_pop) begin
          cells_d[i] = (i < CAPACITY - 1) ? cells_q[(i < CAPACITY - 1) ? i + 1 : i] : cells_q[i];
        end else if (keep[i]) begin
          cells_d[i] = cells_q[i];
        end else if (keep[i-1]) begin
          cells_d[i] = new_entry;
        end else begin
          cells_d[i] = cells_q[i-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && (do_push || do_pop)) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_d        = '0;
    out_d.count  = COUNT_W'(count_d);
    if ((req_q.cmd == CMD_PUSH) && full) begin
      out_d.status = STATUS_FULL;
    end else if ((req_q.cmd == CMD_POP) && empty) begin
      out_d.status = STATUS_EMPTY;
    end else begin
      out_d.status = STATUS_OK;
    end
    if (count_d != '0) begin
      out_d.top_valid    = 1'b1;
      out_d.top_tag      = (do_push || do_pop) ? cells_d[0].tag : cells_q[0].tag;
      out_d.top_priority = (do_push || do_pop) ? cells_d[0].prio : cells_q[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

### sv/mpq_ctrl.sv
// Controller of the priority queue: input and output handshakes and sequencing of each command.
module mpq_ctrl import mpq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q;
  logic state_d;
  logic out_valid_q;
  logic out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_EXEC);

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/max_priority_queue_top.sv
// Top level of the bounded max-first priority queue.
// Each command transfer is handled in order: the command is captured first, then the
// sorted cell chain shifts and the result register is loaded once it is free to be loaded,
// so a new command is taken only after the previous one has completed. The chain keeps
// entries in descending priority with earlier insertions first among equals, so the top
// entry is always the head cell. A result waiting in the output register does not block
// the capture of the next command, only its completion.
module max_priority_queue_top import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  dp_cmd_t dp_cmd;

  mpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  mpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/mpq_checker.sv
// Port-level checker for the priority queue and its bind to the top level.
module mpq_port_checker import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  localparam bit SMALL = (CAPACITY < 32);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Only one command is in progress at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while another was in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL |-> out_data_o.count <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL |-> out_data_o.top_valid == (out_data_o.count != '0))
    else $error("top valid flag disagrees with count");

  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.top_valid |->
      out_data_o.top_tag == '0 && out_data_o.top_priority == '0)
    else $error("top fields not cleared on an empty queue");

endmodule

bind max_priority_queue_top mpq_port_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

### tb/mpq_checker.sv
// Checker that predicts and compares every result transfer of the priority queue.
`timescale 1ns / 1ps
module mpq_checker import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o
);

  entry_t      held_entries[CAPACITY];
  int unsigned held_count;
  out_t        expected_results[$];
  out_t        oldest;
  int          mismatches;

  function automatic int unsigned top_index();
    int unsigned best = 0;
    for (int unsigned i = 1; i < held_count; i++) begin
      if ($signed(held_entries[i].prio) > $signed(held_entries[best].prio)) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic out_t apply_command(in_t command);
    out_t        res;
    int unsigned idx;
    res = '0;
    res.status = STATUS_OK;
    if (command.cmd == CMD_PUSH) begin
      if (held_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        held_entries[held_count].tag  = command.tag;
        held_entries[held_count].prio = command.priority_req;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      idx = top_index();
      for (int unsigned j = idx; j + 1 < held_count; j++) begin
        held_entries[j] = held_entries[j + 1];
      end
      held_count--;
    end
    res.count = COUNT_W'(held_count);
    if (held_count != 0) begin
      idx = top_index();
      res.top_valid    = 1'b1;
      res.top_tag      = held_entries[idx].tag;
      res.top_priority = held_entries[idx].prio;
    end
    return res;
  endfunction

  task automatic report_failure(string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s mismatch: got %0h, wanted %0h", field, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_failure("Result transfer with no command outstanding.");
        end else begin
          oldest = expected_results.pop_front();
          compare_field("status", 32'(out_data_i.status), 32'(oldest.status));
          compare_field("count", 32'(out_data_i.count), 32'(oldest.count));
          compare_field("top_valid", 32'(out_data_i.top_valid), 32'(oldest.top_valid));
          compare_field("top_tag", 32'(out_data_i.top_tag), 32'(oldest.top_tag));
          compare_field("top_priority", 32'(unsigned'(out_data_i.top_priority)),
                        32'(unsigned'(oldest.top_priority)));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results = {expected_results, apply_command(in_data_i)};
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, command stimulus, result stalls and the final verdict.
`timescale 1ns / 1ps
module tb;
  import mpq_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned ITEMS       = 2000;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_OFF    = 200;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int          mismatches;
  int          pending;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;
  bit          held_off = 1'b0;

  max_priority_queue_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  mpq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic signed [15:0] random_priority();
    case ($urandom_range(3))
      0:       return 16'sh8000 + 16'($urandom_range(2));
      1:       return 16'sh7fff - 16'($urandom_range(2));
      2:       return 16'($urandom_range(4)) - 16'sd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t push_cmd(logic [15:0] tag, logic signed [15:0] prio);
    in_t item;
    item.cmd          = CMD_PUSH;
    item.tag          = tag;
    item.priority_req = prio;
    return item;
  endfunction

  function automatic in_t pop_cmd();
    in_t item;
    item.cmd          = CMD_POP;
    item.tag          = 16'($urandom);
    item.priority_req = 16'($urandom);
    return item;
  endfunction

  task automatic send_command(in_t item);
    if ((sent < 1000 || sent >= 1400) && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent <= sent + 1;
  endtask

  initial begin
    int unsigned push_pct;
    wait (rst_n);
    @(posedge clk);

    send_command(pop_cmd());
    send_command(push_cmd(16'h0000, 16'sh8000));
    send_command(push_cmd(16'hffff, 16'sh7fff));
    send_command(push_cmd(16'h1234, 16'sh7fff));
    send_command(push_cmd(16'haaaa, 16'sd0));
    send_command(push_cmd(16'h5555, -16'sd1));
    for (int i = 0; i < 11; i++) begin
      send_command(push_cmd(16'($urandom), random_priority()));
    end
    send_command(push_cmd(16'hffff, 16'sh7fff));
    for (int i = 0; i < 7; i++) begin
      send_command(pop_cmd());
    end

    push_pct = 50;
    for (int i = 25; i < ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        send_command(push_cmd(16'($urandom), random_priority()));
      end else begin
        send_command(pop_cmd());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // The receiver holds off once for a long stretch so that the queue backs up into its input.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && sent >= 300) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end
      out_stall <= (sent >= 1200 && sent < 1600) ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
